// ===== hw/rtl/rpn_stack_calculator_macros.svh =====
// Assertion macros for the RPN calculator checker.
// Included by rpn_stack_calculator_checker.sv.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH
// clocked implication, reset gated
`define RPN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// plain clocked check, not reset gated
`define RPN_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hw/rtl/rpn_pkg.sv =====
// Package for the RPN stack calculator: types, opcodes, status codes, depth.
// No dependencies.
package rpn_pkg;
   localparam int StackDepth = 128;
   localparam int DepthW = $clog2(StackDepth + 1);
   localparam int CntW = 8;

   typedef enum logic [3:0] {
      KIND_PUSH = 4'd0, KIND_ADD = 4'd1, KIND_SUB = 4'd2, KIND_MUL = 4'd3,
      KIND_DIV = 4'd4, KIND_MOD = 4'd5, KIND_PEEK = 4'd6, KIND_DUP = 4'd7,
      KIND_SWAP = 4'd8, KIND_CLEAR = 4'd9, KIND_POP_SHOW = 4'd10
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_DIVZERO = 3'd3,
      ST_SWAP = 3'd4, ST_SAT = 3'd5
   } status_type;

   // stack cell operations; the whole row shifts in lock step
   typedef enum logic [2:0] {
      CELL_HOLD, CELL_PUSH, CELL_POP, CELL_POP2_PUSH, CELL_SWAP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [31:0] value;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_MUL, S_DIV, S_FIN, S_OUT
   } state_type;

   function automatic logic [31:0] sat32(input logic signed [65:0] x, output logic sat);
      sat = 1'b0;
      if (x > 66'sh0_7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (x < -66'sh0_8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction
endpackage

// ===== hw/rtl/rpn_if.sv =====
// Valid/ready channel interface for requests and responses.
// Depends on nothing; payload fields are fixed per channel.
interface rpn_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic signed [31:0] operand_value;
   modport source (output valid, kind, operand_value, input ready);
   modport sink (input valid, kind, operand_value, output ready);
endinterface

interface rpn_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] shown_value;
   logic        shown_valid;
   logic [2:0]  status;
   logic [7:0]  stack_depth;
   modport source (output valid, shown_value, shown_valid, status, stack_depth,
                   input ready);
   modport sink (input valid, shown_value, shown_valid, status, stack_depth,
                 output ready);
endinterface

// ===== hw/rtl/rpn_cell.sv =====
// One stack cell: holds one entry and trades with its neighbors.
// Depends on rpn_pkg.
module rpn_cell import rpn_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [31:0]  above_val,   // cell i-1 (nearer top)
   input  logic [31:0]  below_val,   // cell i+1
   input  logic         is_top,
   input  logic         is_second,
   output logic [31:0]  val
);
   logic [31:0] val_ff, val_in;

   always_comb begin
      val_in = val_ff;
      case (ctl.op)
         CELL_PUSH: val_in = is_top ? ctl.value : above_val;
         CELL_POP: val_in = below_val;
         CELL_POP2_PUSH: val_in = is_top ? ctl.value : below_val;
         CELL_SWAP: begin
            if (is_top) val_in = below_val;
            else if (is_second) val_in = above_val;
         end
         default: val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
endmodule

// ===== hw/rtl/rpn_divider.sv =====
// Restoring divider, one quotient bit per cycle, signed operands.
// Depends on rpn_pkg.
module rpn_divider import rpn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic signed [63:0] divisor,
   output logic               done,
   output logic signed [64:0] quotient,
   output logic signed [64:0] remainder
);
   logic [63:0] q_ff, q_in, d_ff, d_in;
   logic [64:0] r_ff, r_in, trial;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic        done_ff;

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; qneg_in = qneg_ff; rneg_in = rneg_ff;
      trial = '0;
      if (start) begin
         q_in = dividend[63] ? 64'(-dividend) : dividend;
         d_in = divisor[63] ? 64'(-divisor) : divisor;
         r_in = '0;
         cnt_in = 7'd64;
         busy_in = 1'b1;
         qneg_in = dividend[63] ^ divisor[63];
         rneg_in = dividend[63];
      end else if (busy_ff) begin
         trial = {r_ff[63:0], q_ff[63]} - {1'b0, d_ff};
         if (!trial[64]) begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[63:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         done_ff <= busy_ff && (cnt_ff == 7'd1);
      end
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   // one-cycle pulse, results stable from here until the next start
   assign done = done_ff;
   assign quotient = qneg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   assign remainder = rneg_ff ? -$signed(r_ff) : $signed(r_ff);
endmodule

// ===== hw/rtl/rpn_stack_calculator.sv =====
// RPN stack calculator, top level. Instantiates the cell row and the divider.
// Depends on rpn_pkg, rpn_if, rpn_cell, rpn_divider.
//
// Usage: one request on req (kind, operand_value) yields exactly one response
// on rsp (shown_value, shown_valid, status, stack_depth). Values are signed
// Q16.16. The stack lives in a row of StackDepth cells; cell 0 is the top
// and every push or pop moves the whole row by one place at once; a swap
// exchanges only the top two cells. Requests are handled one at a time.
// After the accepting edge, push, pop, peek, dup, swap, clear, add, sub and
// any divide by zero go through S_EXEC to S_OUT, where the response is
// valid; mul goes through S_EXEC, S_MUL and S_FIN (product registered
// before scaling); div and mod go through S_EXEC, S_DIV and S_FIN, waiting
// in S_DIV while the bit-serial divider forms all 64 quotient bits.
// req.ready is high only while the core is idle. If the receiver stalls, the
// response holds on rsp until taken and no new request is accepted.
// Reset (synchronous, active high) empties the stack and clears the
// handshake; cell contents are not cleared, cells beyond the depth are
// never read.
module rpn_stack_calculator import rpn_pkg::*; (
   input logic clock,
   input logic reset,
   rpn_req_if.sink   req,
   rpn_rsp_if.source rsp
);
   state_type state_ff, state_in;
   logic [3:0]  kind_ff;
   logic [31:0] opv_ff;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] shown_ff, shown_in;
   logic        shownv_ff, shownv_in;
   logic signed [63:0] prod_ff;
   cell_ctl_type ctl;
   logic [31:0] cell_val [StackDepth+1];
   logic        div_start;
   logic signed [63:0] div_a, div_b;
   logic        div_done;
   logic signed [64:0] div_q, div_r;
   logic signed [31:0] a_s, b_s;
   logic        a_empty, b_empty;

   // operand fetch straight from the top two cells
   always_comb begin
      b_empty = depth_ff == '0;
      a_empty = depth_ff < DepthW'(2);
      b_s = b_empty ? '0 : $signed(cell_val[0]);
      a_s = a_empty ? '0 : $signed(cell_val[1]);
   end

   genvar gi;
   generate
      for (gi = 0; gi < StackDepth; gi++) begin : g_cell
         rpn_cell u_cell (
            .clock(clock), .ctl(ctl),
            .above_val(gi == 0 ? 32'd0 : cell_val[(gi == 0) ? 0 : gi-1]),
            .below_val(cell_val[gi+1]),
            .is_top(gi == 0), .is_second(gi == 1), .val(cell_val[gi])
         );
      end
   endgenerate
   assign cell_val[StackDepth] = '0;

   // divide and mod operands; mod works on truncated integer parts
   logic signed [31:0] bi_s, ai_s;
   logic        div_zero;
   always_comb begin
      bi_s = b_s / 32'sd65536;
      ai_s = a_s / 32'sd65536;
      div_zero = (kind_ff == KIND_DIV && b_s == '0) ||
                 (kind_ff == KIND_MOD && bi_s == '0);
      if (kind_ff == KIND_DIV) begin
         div_a = 64'(a_s) <<< 16;
         div_b = 64'(b_s);
      end else begin
         div_a = 64'(ai_s);
         div_b = 64'(bi_s);
      end
   end

   rpn_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid) state_in = S_EXEC;
         S_EXEC: begin
            if (kind_ff == KIND_MUL) state_in = S_MUL;
            else if ((kind_ff == KIND_DIV || kind_ff == KIND_MOD) && !div_zero)
               state_in = S_DIV;
            else state_in = S_OUT;
         end
         S_MUL: state_in = S_FIN;
         S_DIV: if (div_done) state_in = S_FIN;
         S_FIN: state_in = S_OUT;
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   logic signed [65:0] res_wide;
   logic [31:0] res_sat;
   logic        res_is_sat;
   always_comb begin
      ctl = '{op: CELL_HOLD, value: '0};
      depth_in = depth_ff;
      status_in = status_ff;
      shown_in = shown_ff;
      shownv_in = shownv_ff;
      div_start = 1'b0;
      res_wide = '0;
      unique case (kind_ff)
         KIND_ADD: res_wide = 66'(a_s) + 66'(b_s);
         KIND_SUB: res_wide = 66'(a_s) - 66'(b_s);
         KIND_MUL: res_wide = 66'(prod_ff >>> 16);
         KIND_DIV: res_wide = 66'(div_q);
         default: res_wide = 66'(div_r) <<< 16;
      endcase
      res_sat = sat32(res_wide, res_is_sat);
      if (state_ff == S_IDLE) begin
         status_in = ST_OK; shown_in = '0; shownv_in = 1'b0;
      end
      if (state_ff == S_EXEC) begin
         case (kind_ff) inside
            KIND_PUSH, KIND_DUP: begin
               if (depth_ff == DepthW'(StackDepth)) status_in = ST_FULL;
               else begin
                  ctl = '{op: CELL_PUSH, value: (kind_ff == KIND_PUSH) ? opv_ff : b_s};
                  depth_in = depth_ff + DepthW'(1);
               end
               if (kind_ff == KIND_DUP && b_empty) status_in = ST_EMPTY;
            end
            KIND_ADD, KIND_SUB: begin
               if (a_empty) status_in = ST_EMPTY;
               else if (res_is_sat) status_in = ST_SAT;
               if (depth_ff >= DepthW'(2)) begin
                  ctl = '{op: CELL_POP2_PUSH, value: res_sat};
                  depth_in = depth_ff - DepthW'(1);
               end else begin
                  ctl = '{op: CELL_PUSH, value: res_sat};
                  depth_in = DepthW'(1);
                  if (b_empty == 1'b0) ctl.op = CELL_POP2_PUSH;
               end
            end
            KIND_MUL, KIND_DIV, KIND_MOD: begin
               // right operand read, then divisor check, then left operand read
               if (b_empty) status_in = ST_EMPTY;
               else if (div_zero) status_in = ST_DIVZERO;
               else if (a_empty) status_in = ST_EMPTY;
               if (div_zero) begin
                  if (!b_empty) begin
                     ctl.op = CELL_POP; depth_in = depth_ff - DepthW'(1);
                  end
               end else if (kind_ff != KIND_MUL) begin
                  div_start = 1'b1;
               end
            end
            KIND_PEEK: begin
               shown_in = b_s; shownv_in = 1'b1;
               if (b_empty) status_in = ST_EMPTY;
            end
            KIND_POP_SHOW: begin
               shown_in = b_s; shownv_in = 1'b1;
               if (b_empty) status_in = ST_EMPTY;
               else begin ctl.op = CELL_POP; depth_in = depth_ff - DepthW'(1); end
            end
            KIND_SWAP: begin
               if (a_empty) status_in = ST_SWAP;
               else ctl.op = CELL_SWAP;
            end
            KIND_CLEAR: depth_in = '0;
            default: ;
         endcase
      end
      if (state_ff == S_FIN) begin
         if (status_in == ST_OK && res_is_sat) status_in = ST_SAT;
         if (depth_ff >= DepthW'(2)) begin
            ctl = '{op: CELL_POP2_PUSH, value: res_sat};
            depth_in = depth_ff - DepthW'(1);
         end else begin
            ctl = '{op: (depth_ff == DepthW'(1)) ? CELL_POP2_PUSH : CELL_PUSH,
                    value: res_sat};
            depth_in = DepthW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
      end
      if (state_ff == S_IDLE && req.valid) begin
         kind_ff <= req.kind;
         opv_ff <= req.operand_value;
      end
      prod_ff <= 64'(a_s) * 64'(b_s);
      status_ff <= status_in;
      shown_ff <= shown_in;
      shownv_ff <= shownv_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.shown_value = shown_ff;
   assign rsp.shown_valid = shownv_ff;
   assign rsp.status = status_ff;
   assign rsp.stack_depth = CntW'(depth_ff);
endmodule

// ===== hw/rtl/rpn_stack_calculator_checker.sv =====
// Port-level checker for the RPN calculator, bound to the top level.
// Depends on rpn_pkg, rpn_if and the macro header.
`include "rpn_stack_calculator_macros.svh"
module rpn_checker import rpn_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid, req_ready, rsp_valid, rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_stack_depth
);
   `RPN_ASSERT(a_depth_range, clock, reset, rsp_valid |-> rsp_stack_depth <= 8'(StackDepth), "depth over range")
   `RPN_ASSERT(a_status_range, clock, reset, rsp_valid |-> rsp_status <= 3'd5, "bad status")
   `RPN_ASSERT(a_no_accept_busy, clock, reset, rsp_valid |-> !req_ready, "request taken while busy")
   `RPN_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
endmodule

bind rpn_stack_calculator rpn_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_stack_depth(rsp.stack_depth)
);
